@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, disabled in rst.
`define LNMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, disabled in rst.
`define LNMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lnmd_pkg.sv @@
// Package for the log-number multiply/divide unit: widths, codes, stage records.
`default_nettype none

package lnmd_pkg;

  localparam int CODE_W = 16;
  localparam int DIST_W = 15;
  localparam int KIND_W = 3;
  localparam int SUM_W  = 18;

  localparam logic [CODE_W-1:0] CODE_ZERO  = 16'h0000;
  localparam logic [CODE_W-1:0] CODE_NAN   = 16'hFFFF;
  localparam logic [CODE_W-1:0] AXIS_LOW   = 16'h7FFF;
  localparam logic [CODE_W-1:0] AXIS_HIGH  = 16'h8000;
  localparam logic [DIST_W-1:0] DIST_MAX   = 15'h7FFF;
  localparam logic [DIST_W-1:0] DIST_MIN   = 15'h0001;
  localparam logic [SUM_W-1:0]  LOG_OFFSET = 18'h03FFF;
  localparam logic [SUM_W-1:0]  RECIP_TOP  = 18'h07FFE;

  localparam logic [KIND_W-1:0] KIND_MUL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DIV   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RECIP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NEG   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ABS   = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code_a;
    logic              zero_a;
    logic              nan_a;
    logic              neg_a;
    logic              zero_b;
    logic              nan_b;
    logic              neg_b;
    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;
  } dec_t;

  typedef struct packed {
    logic              build;
    logic              neg;
    logic [SUM_W-1:0]  span;
    logic [CODE_W-1:0] code;
  } calc_t;

endpackage

`default_nettype wire

@@ rtl/core/lnmd_ifs.sv @@
// Request and response channel interfaces of the log-number multiply/divide unit.
`default_nettype none

interface lnmd_req_if;
  import lnmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] operand_a;
  logic [CODE_W-1:0] operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface lnmd_rsp_if;
  import lnmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] result_code;
  logic              result_is_zero;
  logic              result_is_nan;
  logic              result_is_negative;

  modport source (output valid, result_code, result_is_zero, result_is_nan,
                  result_is_negative, input ready);
  modport sink   (input valid, result_code, result_is_zero, result_is_nan,
                  result_is_negative, output ready);
endinterface

`default_nettype wire

@@ rtl/core/log_number_mul_div_unit.sv @@
// Top level: three-stage pipelined log-number multiply/divide/reciprocal/negate/abs unit.
//
//   channel  dir  payload                                        request
//   req      in   kind[2:0], operand_a[15:0], operand_b[15:0]     valid & ready
//   rsp      out  result_code[15:0], result_is_zero/nan/negative  valid & ready
//
// A request passes the s1, s2 and response registers; one request per cycle while rsp is not stalled.
// Stages: operand decode, distance add/subtract, clamp and code build.
// rst clears the stage valid bits only; data registers are not reset.
// A stalled rsp holds each stage that is full; req.ready drops only when all
// three stages hold a request.
`default_nettype none
`include "assert_macros.svh"

module log_number_mul_div_unit (
  input  logic       clk,
  input  logic       rst,
  lnmd_req_if.sink   req,
  lnmd_rsp_if.source rsp
);
  import lnmd_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;
  dec_t  s1, s1_next;
  calc_t s2, s2_next;
  logic [CODE_W-1:0] code3_next;
  logic [DIST_W-1:0] clamp;

  assign en3 = !v3 || rsp.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  // stage 1: classify operands
  always_comb begin
    s1_next.kind   = req.kind;
    s1_next.code_a = req.operand_a;
    s1_next.zero_a = (req.operand_a == CODE_ZERO);
    s1_next.nan_a  = (req.operand_a == CODE_NAN);
    s1_next.neg_a  = (req.operand_a != CODE_ZERO) && !req.operand_a[CODE_W-1];
    s1_next.zero_b = (req.operand_b == CODE_ZERO);
    s1_next.nan_b  = (req.operand_b == CODE_NAN);
    s1_next.neg_b  = (req.operand_b != CODE_ZERO) && !req.operand_b[CODE_W-1];
    s1_next.dist_a = req.operand_a[CODE_W-1] ? DIST_W'(req.operand_a - AXIS_LOW)
                                             : DIST_W'(AXIS_HIGH - req.operand_a);
    s1_next.dist_b = req.operand_b[CODE_W-1] ? DIST_W'(req.operand_b - AXIS_LOW)
                                             : DIST_W'(AXIS_HIGH - req.operand_b);
  end

  // stage 2: raw distance and special-case code
  always_comb begin
    s2_next.build = 1'b0;
    s2_next.neg   = s1.neg_a ^ s1.neg_b;
    s2_next.span  = '0;
    s2_next.code  = CODE_NAN;
    case (s1.kind)
      KIND_MUL: begin
        s2_next.span = SUM_W'(s1.dist_a) + SUM_W'(s1.dist_b) - LOG_OFFSET;
        if (s1.zero_a || s1.zero_b) begin
          s2_next.code = CODE_ZERO;
        end else if (!(s1.nan_a || s1.nan_b)) begin
          s2_next.build = 1'b1;
        end
      end
      KIND_DIV: begin
        s2_next.span = SUM_W'(s1.dist_a) - SUM_W'(s1.dist_b) + LOG_OFFSET;
        if (s1.zero_b || s1.nan_b || s1.nan_a) begin
          s2_next.code = CODE_NAN;
        end else if (s1.zero_a) begin
          s2_next.code = CODE_ZERO;
        end else begin
          s2_next.build = 1'b1;
        end
      end
      KIND_RECIP: begin
        s2_next.span  = RECIP_TOP - SUM_W'(s1.dist_a);
        s2_next.neg   = s1.neg_a;
        s2_next.build = !(s1.zero_a || s1.nan_a);
      end
      KIND_NEG: begin
        s2_next.code = ~s1.code_a;
      end
      KIND_ABS: begin
        s2_next.code = s1.neg_a ? ~s1.code_a : s1.code_a;
      end
      default: begin
        s2_next.code = CODE_NAN;
      end
    endcase
  end

  // stage 3: clamp distance to 1..max and build the code
  always_comb begin
    if (s2.span[SUM_W-1] || (s2.span == '0)) begin
      clamp = DIST_MIN;
    end else if (s2.span[SUM_W-2:DIST_W] != '0) begin
      clamp = DIST_MAX;
    end else begin
      clamp = s2.span[DIST_W-1:0];
    end
    if (!s2.build) begin
      code3_next = s2.code;
    end else if (s2.neg) begin
      code3_next = AXIS_HIGH - CODE_W'(clamp);
    end else begin
      code3_next = AXIS_LOW + CODE_W'(clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) begin
      rsp.result_code        <= code3_next;
      rsp.result_is_zero     <= (code3_next == CODE_ZERO);
      rsp.result_is_nan      <= (code3_next == CODE_NAN);
      rsp.result_is_negative <= (code3_next != CODE_ZERO) && !code3_next[CODE_W-1];
    end
  end

  assign rsp.valid = v3;

  `LNMD_ASSERT_IMP(a_flags_exclusive, rsp.valid, $onehot0({rsp.result_is_zero, rsp.result_is_nan, rsp.result_is_negative}), "result flags overlap")
  `LNMD_ASSERT_IMP(a_stall_only_full, !req.ready, v1 && v2 && v3 && !rsp.ready, "req.ready low with a free stage")
  `LNMD_ASSERT_NXT(a_build_nonspecial, en3 && v2 && s2.build, !rsp.result_is_zero && !rsp.result_is_nan, "built code is zero or NaN")

endmodule

`default_nettype wire
